// ----- design/ptt_pkg.sv -----
package ptt_pkg;

    localparam int ENTRIES      = 16;
    localparam int WARMUP_TICKS = 10;
    localparam int MAX_RESULTS  = 16;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int K_W    = $clog2(MAX_RESULTS + 1);
    localparam int WARM_W = 4;
    localparam int CH_W   = 8;
    localparam int PER_W  = 16;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_REGISTER   = 2'd1,
        OP_UNREGISTER = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_FIRED   = 2'd0,
        KIND_APPLIED = 2'd1,
        KIND_DROPPED = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_FIND  = 3'd1,
        S_APPLY = 3'd2,
        S_TICK  = 3'd3
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [CH_W-1:0]  channel;
        logic [PER_W-1:0] period;
    } t_item;

endpackage

// ----- design/ptt_front.sv -----
module ptt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic           i_cmd,
    input  logic [7:0]     i_channel_id,
    input  logic [15:0]    i_period,
    output logic           o_item_valid,
    input  logic           i_item_stall,
    output ptt_pkg::t_item o_item
);
    import ptt_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int FILL_W = $clog2(QDEPTH + 1);

    t_item               r_q [QDEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [FILL_W-1:0]   r_fill;
    t_item               w_item;
    logic                w_push;
    logic                w_pop;

    always_comb begin
        w_item.channel = i_channel_id;
        w_item.period  = i_period;
        if (!i_cmd) begin
            w_item.op = OP_TICK;
        end else if (i_period != '0) begin
            w_item.op = OP_REGISTER;
        end else begin
            w_item.op = OP_UNREGISTER;
        end
    end

    assign o_stall      = (r_fill == FILL_W'(QDEPTH));
    assign o_item_valid = (r_fill != '0);
    assign o_item       = r_q[r_rd_ptr];
    assign w_push       = i_valid && !o_stall;
    assign w_pop        = o_item_valid && !i_item_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ----- design/ptt_back.sv -----
module ptt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    output logic           o_item_stall,
    input  ptt_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [1:0]     o_event_kind,
    output logic [7:0]     o_event_channel,
    output logic           o_last
);
    import ptt_pkg::*;

    t_state             r_state;
    t_state             n_state;

    logic [CH_W-1:0]    r_chan [ENTRIES];
    logic [PER_W-1:0]   r_per  [ENTRIES];
    logic [PER_W-1:0]   r_cnt  [ENTRIES];
    logic [CNT_W-1:0]   r_n;

    t_op                r_op;
    logic [CH_W-1:0]    r_ch;
    logic [PER_W-1:0]   r_period;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_f;
    logic               r_found;
    logic               r_armed;
    logic [K_W-1:0]     r_k;
    logic               r_pend_valid;
    logic [CH_W-1:0]    r_pend_ch;
    logic [WARM_W-1:0]  r_warm;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [CH_W-1:0]    r_out_ch;
    logic               r_out_last;

    logic [IDX_W-1:0]   w_slot;
    logic               w_in_range;
    logic               w_out_free;
    logic               w_hit;
    logic               w_report;
    logic               w_take;
    logic               w_find_hit;
    logic               w_find_adv;
    logic               w_apply;
    logic               w_tick_step;
    logic               w_tick_done;
    logic               w_emit;
    t_kind              w_emit_kind;
    logic [CH_W-1:0]    w_emit_ch;
    logic               w_emit_last;
    logic               w_drop;

    assign w_slot     = r_idx[IDX_W-1:0];
    assign w_in_range = (r_idx < r_n);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_hit      = (r_cnt[w_slot] == r_per[w_slot]);
    assign w_report   = w_hit && r_armed && (r_k < K_W'(MAX_RESULTS));
    assign w_drop     = (r_op == OP_REGISTER) && !r_found && (r_n >= CNT_W'(ENTRIES));

    assign o_item_stall    = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_event_kind    = r_out_kind;
    assign o_event_channel = r_out_ch;
    assign o_last          = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_take      = 1'b0;
        w_find_hit  = 1'b0;
        w_find_adv  = 1'b0;
        w_apply     = 1'b0;
        w_tick_step = 1'b0;
        w_tick_done = 1'b0;
        w_emit      = 1'b0;
        w_emit_kind = KIND_APPLIED;
        w_emit_ch   = r_ch;
        w_emit_last = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    w_take  = 1'b1;
                    n_state = (i_item.op == OP_TICK) ? S_TICK : S_FIND;
                end
            end
            S_FIND: begin
                if (!w_in_range) begin
                    n_state = S_APPLY;
                end else if (r_chan[w_slot] == r_ch) begin
                    w_find_hit = 1'b1;
                    n_state    = S_APPLY;
                end else begin
                    w_find_adv = 1'b1;
                end
            end
            S_APPLY: begin
                if (w_out_free) begin
                    w_apply     = 1'b1;
                    w_emit      = 1'b1;
                    w_emit_kind = w_drop ? KIND_DROPPED : KIND_APPLIED;
                    n_state     = S_IDLE;
                end
            end
            S_TICK: begin
                w_emit_kind = KIND_FIRED;
                w_emit_ch   = r_pend_ch;
                if (!w_in_range) begin
                    if (!r_pend_valid || w_out_free) begin
                        w_tick_done = 1'b1;
                        w_emit      = r_pend_valid;
                        n_state     = S_IDLE;
                    end
                end else if (!(w_report && r_pend_valid && !w_out_free)) begin
                    w_tick_step = 1'b1;
                    w_emit      = w_report && r_pend_valid;
                    w_emit_last = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op     <= i_item.op;
            r_ch     <= i_item.channel;
            r_period <= i_item.period;
        end
        if (w_find_hit) begin
            r_f <= r_idx;
        end
        if (w_tick_step && w_report) begin
            r_pend_ch <= r_chan[w_slot];
        end
        if (w_emit) begin
            r_out_kind <= w_emit_kind;
            r_out_ch   <= w_emit_ch;
            r_out_last <= w_emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply && !w_drop) begin
            if (r_op == OP_REGISTER) begin
                for (int i = 1; i < ENTRIES; i++) begin
                    if (CNT_W'(i) <= (r_found ? r_f : r_n)) begin
                        r_chan[i] <= r_chan[i-1];
                        r_per[i]  <= r_per[i-1];
                        r_cnt[i]  <= r_cnt[i-1];
                    end
                end
                r_chan[0] <= r_ch;
                r_per[0]  <= r_period;
                r_cnt[0]  <= '0;
            end else if (r_found) begin
                for (int i = 0; i < ENTRIES - 1; i++) begin
                    if ((CNT_W'(i) >= r_f) && (CNT_W'(i + 1) < r_n)) begin
                        r_chan[i] <= r_chan[i+1];
                        r_per[i]  <= r_per[i+1];
                        r_cnt[i]  <= r_cnt[i+1];
                    end
                end
            end
        end else if (w_tick_step) begin
            if (!w_hit) begin
                r_cnt[w_slot] <= r_cnt[w_slot] + 1'b1;
            end else if (r_armed) begin
                r_cnt[w_slot] <= PER_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n          <= '0;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_armed      <= 1'b0;
            r_k          <= '0;
            r_pend_valid <= 1'b0;
            r_warm       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_take) begin
                r_idx        <= '0;
                r_found      <= 1'b0;
                r_k          <= '0;
                r_pend_valid <= 1'b0;
                r_armed      <= (r_warm > WARM_W'(WARMUP_TICKS));
            end
            if (w_find_hit) begin
                r_found <= 1'b1;
            end
            if (w_find_adv || w_tick_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_tick_step && w_report) begin
                r_pend_valid <= 1'b1;
                r_k          <= r_k + 1'b1;
            end
            if (w_tick_done) begin
                r_pend_valid <= 1'b0;
                if (r_warm <= WARM_W'(WARMUP_TICKS)) begin
                    r_warm <= r_warm + 1'b1;
                end
            end
            if (w_apply && !w_drop) begin
                if ((r_op == OP_REGISTER) && !r_found) begin
                    r_n <= r_n + 1'b1;
                end else if ((r_op == OP_UNREGISTER) && r_found) begin
                    r_n <= r_n - 1'b1;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- design/periodic_timer_table.sv -----
// A table of up to sixteen periodic timer channels, newest entry first.
// The input channel carries one transaction per tick (cmd 0) or per
// register/unregister message (cmd 1, a zero period unregisters the channel).
// The output channel carries event transactions: a fired channel, an applied
// message or a registration dropped because the table is full; o_last marks
// the final event caused by one input transaction. A tick that fires nothing
// produces no event, and a message always produces exactly one.
// Input transactions first enter a two-entry queue, so up to two can be taken
// while the table is busy. The table handles one transaction at a time and
// visits one entry a cycle unless a stalled event holds the scan. A message
// scans the entries up to its channel, or all n occupied entries when it is
// absent, then applies and emits its event; a tick scans all n occupied
// entries and sends its final event, if any, once the scan ends. When the
// receiver stalls, the event register holds its transaction and the scan
// waits on the next event it has to send. Synchronous reset empties the
// table, the queue and the warm-up count.
module periodic_timer_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_channel_id,
    input  logic [15:0] i_period,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_event_channel,
    output logic        o_last
);
    import ptt_pkg::*;

    t_item w_item;
    logic  w_item_valid;
    logic  w_item_stall;

    ptt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_channel_id (i_channel_id),
        .i_period     (i_period),
        .o_item_valid (w_item_valid),
        .i_item_stall (w_item_stall),
        .o_item       (w_item)
    );

    ptt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (w_item_valid),
        .o_item_stall    (w_item_stall),
        .i_item          (w_item),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_kind    (o_event_kind),
        .o_event_channel (o_event_channel),
        .o_last          (o_last)
    );

endmodule
